// ----- hdl/mcst_pkg.sv -----
`default_nettype none
package mcst_pkg;

    localparam int NUM_TIMERS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 16;

    typedef enum logic [3:0] {
        OP_TICK     = 4'd0,
        OP_ADD      = 4'd1,
        OP_KILL     = 4'd2,
        OP_PAUSE    = 4'd3,
        OP_RESUME   = 4'd4,
        OP_RESTART  = 4'd5,
        OP_CHANGE   = 4'd6,
        OP_TAKE     = 4'd7,
        OP_KILL_ALL = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        K_FIRED = 3'd0,
        K_DONE  = 3'd1,
        K_TASK  = 3'd2,
        K_EMPTY = 3'd3,
        K_REJ   = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRD,
        S_CMOD,
        S_QRD,
        S_QMOD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [31:0]        rem;
        logic [31:0]        rld;
        logic signed [31:0] rep;
        logic [7:0]         act;
        logic [31:0]        par;
        logic               dfr;
        logic               act_en;
    } t_chan;

    typedef struct packed {
        logic [7:0]  act;
        logic [31:0] par;
    } t_qent;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  fired_id;
        logic [7:0]  out_action;
        logic [31:0] out_param;
        logic        queue_dropped;
        logic        last;
    } t_res;

endpackage
`default_nettype wire

// ----- hdl/mcst_in_if.sv -----
`default_nettype none
interface mcst_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         op;
    logic [3:0]         chan_id;
    logic [31:0]        period_ticks;
    logic [7:0]         action_code;
    logic [31:0]        action_param;
    logic signed [31:0] repeat_count;
    logic               deferred;

    modport source (output valid, op, chan_id, period_ticks, action_code, action_param,
                    repeat_count, deferred, input ready);
    modport sink (input valid, op, chan_id, period_ticks, action_code, action_param,
                  repeat_count, deferred, output ready);
endinterface
`default_nettype wire

// ----- hdl/mcst_out_if.sv -----
`default_nettype none
interface mcst_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  fired_id;
    logic [7:0]  out_action;
    logic [31:0] out_param;
    logic        queue_dropped;
    logic        last;

    modport source (output valid, kind, fired_id, out_action, out_param, queue_dropped,
                    last, input ready);
    modport sink (input valid, kind, fired_id, out_action, out_param, queue_dropped,
                  last, output ready);
endinterface
`default_nettype wire

// ----- hdl/mcst_out_reg.sv -----
`default_nettype none
module mcst_out_reg
    import mcst_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_load,
    input  t_res        i_res,
    output logic        o_free,
    mcst_out_if.source  o_res
);
    logic r_valid;
    t_res r_res;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.kind          = r_res.kind;
    assign o_res.fired_id      = r_res.fired_id;
    assign o_res.out_action    = r_res.out_action;
    assign o_res.out_param     = r_res.out_param;
    assign o_res.queue_dropped = r_res.queue_dropped;
    assign o_res.last          = r_res.last;
endmodule
`default_nettype wire

// ----- hdl/multi_channel_soft_timer_top.sv -----
// A channel op passes S_CRD, S_CMOD and S_FIN before its result goes to the output register;
// a take of a queued task passes S_QRD, S_QMOD and S_FIN; a rejected op or a take from an
// empty queue goes straight to S_FIN. A tick or kill all walks the channels one at a time,
// each through S_CRD and S_CMOD, and gives its last result from S_FIN. A kill also walks the
// queue through S_QRD and S_QMOD. One item is worked on at a time; in a tick, a full output
// register stalls the walk. Reset is synchronous and active low; the channel table reads as reset.
`default_nettype none
module multi_channel_soft_timer_top
    import mcst_pkg::*;
#(
    parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mcst_in_if.sink    i_cmd,
    mcst_out_if.source o_res
);
    localparam int CW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int QW = $clog2(QUEUE_DEPTH);

    t_state r_state, n_state;

    t_chan  r_ch_mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_ch_vld;
    t_chan  r_ch_q;
    logic   r_ch_qv;
    t_qent  r_q_mem [QUEUE_DEPTH];
    t_qent  r_q_q;

    logic [CW-1:0] r_idx;
    logic [QW-1:0] r_head, r_tail, r_qi;
    t_op           r_op;
    logic [31:0]   r_period, r_par, r_kpar;
    logic [7:0]    r_act, r_kact;
    logic [31:0]   r_rc;
    logic          r_dfr;
    t_res          r_fin;

    t_chan  d, newc;
    logic   hit, expire, need_emit, stall, push, qfull, last_idx, out_free;
    logic [31:0] dec;
    logic   ch_we, q_we, out_load, id_ok, q_match;
    t_qent  q_wdata;
    logic [QW-1:0] q_waddr;
    t_res   res;
    t_kind  acc_kind;

    function automatic logic [QW-1:0] qnext(input logic [QW-1:0] p);
        return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign id_ok = 9'(i_cmd.chan_id) < 9'(NUM_TIMERS);
    assign i_cmd.ready = (r_state == S_IDLE);

    always_comb begin
        acc_kind = K_DONE;
        if (i_cmd.op == OP_TAKE) begin
            if (r_head == r_tail) begin
                acc_kind = K_EMPTY;
            end
        end else if (i_cmd.op > OP_KILL_ALL ||
                     (i_cmd.op != OP_TICK && i_cmd.op != OP_KILL_ALL &&
                      (!id_ok || (i_cmd.op == OP_ADD && i_cmd.repeat_count == 0)))) begin
            acc_kind = K_REJ;
        end
    end

    always_comb begin
        if (r_ch_qv) begin
            d = r_ch_q;
        end else begin
            d = '0;
            d.act_en = 1'b1;
        end
    end

    always_comb begin
        dec       = d.rem - 32'd1;
        hit       = (d.rem != '0) && d.act_en;
        expire    = hit && (dec == '0);
        need_emit = expire && !d.dfr;
        push      = expire && d.dfr;
        qfull     = (qnext(r_tail) == r_head);
        last_idx  = (r_idx == CW'(NUM_TIMERS - 1));
        stall     = (r_op == OP_TICK) && need_emit && !out_free;
        q_match   = (r_q_q.act == r_kact) && (r_q_q.par == r_kpar);
        newc      = d;
        unique case (r_op)
            OP_TICK: begin
                if (hit) begin
                    newc.rem = dec;
                end
                if (expire) begin
                    if (d.rep < 0) begin
                        newc.rem = d.rld;
                    end else if (d.rep != 0) begin
                        newc.rem = d.rld;
                        newc.rep = d.rep - 32'sd1;
                    end
                end
            end
            OP_ADD: begin
                newc.rld    = r_period;
                newc.rem    = r_period;
                newc.act    = r_act;
                newc.par    = r_par;
                newc.rep    = r_rc[31] ? r_rc : r_rc - 32'd1;
                newc.dfr    = r_dfr;
                newc.act_en = 1'b1;
            end
            OP_KILL:     newc.rem = '0;
            OP_PAUSE:    newc.act_en = 1'b0;
            OP_RESUME:   newc.act_en = 1'b1;
            OP_RESTART:  newc.rem = d.rld;
            OP_CHANGE: begin
                newc.rld = r_period;
                newc.rem = r_period;
            end
            OP_KILL_ALL: begin
                newc.rem = '0;
                newc.rep = '0;
            end
            default: newc = d;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    if (i_cmd.op == OP_TICK || i_cmd.op == OP_KILL_ALL) begin
                        n_state = S_CRD;
                    end else if (i_cmd.op == OP_TAKE) begin
                        n_state = (r_head == r_tail) ? S_FIN : S_QRD;
                    end else if (i_cmd.op >= OP_ADD && i_cmd.op <= OP_CHANGE && id_ok &&
                                 !(i_cmd.op == OP_ADD && i_cmd.repeat_count == 0)) begin
                        n_state = S_CRD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_CRD: n_state = S_CMOD;
            S_CMOD: begin
                if (r_op == OP_TICK || r_op == OP_KILL_ALL) begin
                    if (!stall) begin
                        n_state = last_idx ? S_FIN : S_CRD;
                    end
                end else if (r_op == OP_KILL) begin
                    n_state = (r_head == r_tail) ? S_FIN : S_QRD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_QRD: n_state = S_QMOD;
            S_QMOD: begin
                if (r_op == OP_TAKE || qnext(r_qi) == r_tail) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_QRD;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ch_we    = 1'b0;
        q_we     = 1'b0;
        q_waddr  = r_tail;
        q_wdata  = '{act: d.act, par: d.par};
        out_load = 1'b0;
        res      = r_fin;
        unique case (r_state)
            S_CMOD: begin
                ch_we = !stall;
                if (r_op == OP_TICK && !stall) begin
                    q_we = push && !qfull;
                    if (need_emit) begin
                        out_load = 1'b1;
                        res = '{kind: K_FIRED, fired_id: 4'(r_idx), out_action: d.act,
                                out_param: d.par, queue_dropped: 1'b0, last: 1'b0};
                    end
                end
            end
            S_QMOD: begin
                if (r_op == OP_KILL && q_match) begin
                    q_we    = 1'b1;
                    q_waddr = r_qi;
                    q_wdata = '{act: 8'd0, par: r_q_q.par};
                end
            end
            S_FIN: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ch_vld <= '0;
            r_head   <= '0;
            r_tail   <= '0;
        end else begin
            r_state <= n_state;
            if (ch_we) begin
                r_ch_vld[r_idx] <= 1'b1;
            end
            if (r_state == S_IDLE && i_cmd.valid && i_cmd.op == OP_KILL_ALL) begin
                r_head <= r_tail;
            end
            if (r_state == S_CMOD && r_op == OP_TICK && !stall && push && !qfull) begin
                r_tail <= qnext(r_tail);
            end
            if (r_state == S_QMOD && r_op == OP_TAKE) begin
                r_head <= qnext(r_head);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ch_we) begin
            r_ch_mem[r_idx] <= newc;
        end
        if (r_state == S_CRD) begin
            r_ch_q  <= r_ch_mem[r_idx];
            r_ch_qv <= r_ch_vld[r_idx];
        end
        if (q_we) begin
            r_q_mem[q_waddr] <= q_wdata;
        end
        if (r_state == S_QRD) begin
            r_q_q <= r_q_mem[r_qi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd.valid) begin
            r_op     <= t_op'(i_cmd.op);
            r_period <= i_cmd.period_ticks;
            r_act    <= i_cmd.action_code;
            r_par    <= i_cmd.action_param;
            r_rc     <= i_cmd.repeat_count;
            r_dfr    <= i_cmd.deferred;
            r_qi     <= r_head;
            r_fin    <= '{kind: acc_kind, fired_id: 4'd0, out_action: 8'd0, out_param: 32'd0,
                          queue_dropped: 1'b0, last: 1'b1};
            if (i_cmd.op == OP_TICK || i_cmd.op == OP_KILL_ALL) begin
                r_idx <= '0;
            end else begin
                r_idx <= CW'(i_cmd.chan_id);
            end
        end
        if (r_state == S_CMOD) begin
            r_kact <= d.act;
            r_kpar <= d.par;
            if (r_op == OP_TICK && !stall && push && qfull) begin
                r_fin.queue_dropped <= 1'b1;
            end
            if (!stall && !last_idx && (r_op == OP_TICK || r_op == OP_KILL_ALL)) begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (r_state == S_QMOD) begin
            r_qi <= qnext(r_qi);
            if (r_op == OP_TAKE) begin
                r_fin.kind       <= K_TASK;
                r_fin.out_action <= r_q_q.act;
                r_fin.out_param  <= r_q_q.par;
            end
        end
    end

    mcst_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_res   (res),
        .o_free  (out_free),
        .o_res   (o_res)
    );
endmodule
`default_nettype wire

// ----- hdl/mcst_checker.sv -----
`default_nettype none
module mcst_checker
    import mcst_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [2:0] i_kind,
    input wire       i_dropped,
    input wire       i_last
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result withdrawn before its transfer.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("Input taken while an item is still in work.");

    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == K_FIRED |-> !i_last)
        else $error("A firing result closed its item.");

    a_other_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != K_FIRED |-> i_last)
        else $error("A closing result is not marked last.");

    a_drop_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_dropped |-> i_kind == K_DONE)
        else $error("Drop flag on a result other than the tick summary.");
endmodule

bind multi_channel_soft_timer_top mcst_checker u_mcst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_kind      (o_res.kind),
    .i_dropped   (o_res.queue_dropped),
    .i_last      (o_res.last)
);
`default_nettype wire

// ----- tb/tb_scoreboard.sv -----
`timescale 1ns / 1ps
package tb_timer_sb_pkg;
    import mcst_pkg::*;

    class timer_scoreboard;
        logic [31:0]        remaining [16];
        logic [31:0]        reload_val [16];
        logic signed [31:0] repeats [16];
        logic [7:0]         ch_act [16];
        logic [31:0]        ch_par [16];
        bit                 ch_dfr [16];
        bit                 ch_on [16];
        logic [7:0]         q_act [16];
        logic [31:0]        q_par [16];
        logic [3:0]         q_head;
        logic [3:0]         q_tail;
        t_res               pending [$];
        int                 errors;

        function new();
            for (int i = 0; i < 16; i++) begin
                remaining[i] = 0;
                reload_val[i] = 0;
                repeats[i] = 0;
                ch_act[i] = 0;
                ch_par[i] = 0;
                ch_dfr[i] = 0;
                ch_on[i] = 1;
                q_act[i] = 0;
                q_par[i] = 0;
            end
            q_head = 0;
            q_tail = 0;
            errors = 0;
        endfunction

        function int queued();
            return int'(4'(q_tail - q_head));
        endfunction

        function void push_res(t_kind k, logic [3:0] id, logic [7:0] a, logic [31:0] p,
                               logic d, logic l);
            t_res r;
            r.kind = k;
            r.fired_id = id;
            r.out_action = a;
            r.out_param = p;
            r.queue_dropped = d;
            r.last = l;
            pending.push_back(r);
        endfunction

        function void note_command(logic [3:0] op, logic [3:0] id, logic [31:0] period,
                                   logic [7:0] act, logic [31:0] par,
                                   logic signed [31:0] rc, logic dfr);
            logic drop;
            drop = 0;
            if (op == OP_TICK) begin
                for (int i = 0; i < 16; i++) begin
                    if (remaining[i] == 0 || !ch_on[i]) continue;
                    remaining[i]--;
                    if (remaining[i] != 0) continue;
                    if (repeats[i] < 0) begin
                        remaining[i] = reload_val[i];
                    end else if (repeats[i] > 0) begin
                        remaining[i] = reload_val[i];
                        repeats[i]--;
                    end
                    if (!ch_dfr[i]) begin
                        push_res(K_FIRED, 4'(i), ch_act[i], ch_par[i], 0, 0);
                    end else if (4'(q_tail + 1) == q_head) begin
                        drop = 1;
                    end else begin
                        q_act[q_tail] = ch_act[i];
                        q_par[q_tail] = ch_par[i];
                        q_tail++;
                    end
                end
                push_res(K_DONE, 0, 0, 0, drop, 1);
                return;
            end
            case (op)
                OP_ADD: begin
                    if (rc == 0) begin
                        push_res(K_REJ, 0, 0, 0, 0, 1);
                        return;
                    end
                    reload_val[id] = period;
                    remaining[id] = period;
                    ch_act[id] = act;
                    ch_par[id] = par;
                    repeats[id] = (rc < 0) ? rc : rc - 1;
                    ch_dfr[id] = dfr;
                    ch_on[id] = 1;
                end
                OP_KILL: begin
                    remaining[id] = 0;
                    for (logic [3:0] j = q_head; j != q_tail; j++)
                        if (q_act[j] == ch_act[id] && q_par[j] == ch_par[id]) q_act[j] = 0;
                end
                OP_PAUSE: ch_on[id] = 0;
                OP_RESUME: ch_on[id] = 1;
                OP_RESTART: remaining[id] = reload_val[id];
                OP_CHANGE: begin
                    reload_val[id] = period;
                    remaining[id] = period;
                end
                OP_TAKE: begin
                    if (q_head == q_tail) begin
                        push_res(K_EMPTY, 0, 0, 0, 0, 1);
                    end else begin
                        push_res(K_TASK, 0, q_act[q_head], q_par[q_head], 0, 1);
                        q_head++;
                    end
                    return;
                end
                OP_KILL_ALL: begin
                    for (int i = 0; i < 16; i++) begin
                        remaining[i] = 0;
                        repeats[i] = 0;
                    end
                    q_head = q_tail;
                end
                default: begin
                    push_res(K_REJ, 0, 0, 0, 0, 1);
                    return;
                end
            endcase
            push_res(K_DONE, 0, 0, 0, 0, 1);
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                $error("unexpected result kind %0d", got.kind);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.fired_id !== want.fired_id) begin
                $error("fired_id: expected %0d actual %0d", want.fired_id, got.fired_id);
                errors++;
            end
            if (got.out_action !== want.out_action) begin
                $error("out_action: expected %0h actual %0h", want.out_action,
                       got.out_action);
                errors++;
            end
            if (got.out_param !== want.out_param) begin
                $error("out_param: expected %0h actual %0h", want.out_param, got.out_param);
                errors++;
            end
            if (got.queue_dropped !== want.queue_dropped) begin
                $error("queue_dropped: expected %0b actual %0b", want.queue_dropped,
                       got.queue_dropped);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b actual %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass
endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import mcst_pkg::*;
    import tb_timer_sb_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    mcst_in_if  cmd_if ();
    mcst_out_if res_if ();

    multi_channel_soft_timer_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if.sink),
        .o_res  (res_if.source)
    );

    always #1 i_clk = ~i_clk;

    timer_scoreboard sb = new();
    int  cycles = 0;
    bit  hold_off = 0;
    int  q_vals [4];

    initial begin
        cmd_if.valid = 0;
        cmd_if.op = 0;
        cmd_if.chan_id = 0;
        cmd_if.period_ticks = 0;
        cmd_if.action_code = 0;
        cmd_if.action_param = 0;
        cmd_if.repeat_count = 0;
        cmd_if.deferred = 0;
        res_if.ready = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_res r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            r.kind = t_kind'(res_if.kind);
            r.fired_id = res_if.fired_id;
            r.out_action = res_if.out_action;
            r.out_param = res_if.out_param;
            r.queue_dropped = res_if.queue_dropped;
            r.last = res_if.last;
            sb.check_result(r);
        end
    end

    initial begin
        int w;
        @(posedge i_clk);
        while (1) begin
            if (hold_off) begin
                res_if.ready <= 0;
                @(posedge i_clk);
            end else begin
                w = $urandom_range(0, 3);
                if ($urandom_range(0, 3) == 0) w = 0;
                if (w > 0) begin
                    res_if.ready <= 0;
                    repeat (w) @(posedge i_clk);
                end
                res_if.ready <= 1;
                @(posedge i_clk);
                while (!res_if.valid && !hold_off) @(posedge i_clk);
            end
        end
    end

    task automatic send(logic [3:0] op, logic [3:0] id, logic [31:0] period,
                        logic [7:0] act, logic [31:0] par, logic [31:0] rc, logic dfr,
                        bit gaps = 1);
        int w;
        w = gaps ? $urandom_range(0, 3) : 0;
        if (w > 0) begin
            cmd_if.valid <= 0;
            repeat (w) @(posedge i_clk);
        end
        cmd_if.valid <= 1;
        cmd_if.op <= op;
        cmd_if.chan_id <= id;
        cmd_if.period_ticks <= period;
        cmd_if.action_code <= act;
        cmd_if.action_param <= par;
        cmd_if.repeat_count <= rc;
        cmd_if.deferred <= dfr;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        sb.note_command(op, id, period, act, par, rc, dfr);
    endtask

    task automatic send_random();
        int sel;
        logic [3:0] op;
        logic [31:0] period, par, rc;
        sel = $urandom_range(0, 99);
        if (sel < 35) op = OP_TICK;
        else if (sel < 55) op = OP_ADD;
        else if (sel < 62) op = OP_KILL;
        else if (sel < 66) op = OP_PAUSE;
        else if (sel < 70) op = OP_RESUME;
        else if (sel < 74) op = OP_RESTART;
        else if (sel < 78) op = OP_CHANGE;
        else if (sel < 94) op = OP_TAKE;
        else if (sel < 96) op = OP_KILL_ALL;
        else op = 4'($urandom_range(9, 15));
        period = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5);
        par = ($urandom_range(0, 1)) ? $urandom : q_vals[$urandom_range(0, 3)];
        case ($urandom_range(0, 5))
            0: rc = $urandom;
            1: rc = 0;
            2: rc = 32'hFFFF_FFFF;
            default: rc = $urandom_range(1, 4);
        endcase
        send(op, 4'($urandom), period,
             ($urandom_range(0, 1)) ? 8'($urandom) : 8'($urandom_range(1, 3)),
             par, rc, 1'($urandom));
    endtask

    initial begin
        for (int i = 0; i < 4; i++) q_vals[i] = $urandom;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send(OP_TICK, 0, 0, 0, 0, 0, 0);
        send(OP_TAKE, 0, 0, 0, 0, 0, 0);
        send(OP_ADD, 0, 1, 8'hFF, 32'hFFFF_FFFF, 32'h8000_0000, 0);
        send(OP_ADD, 15, 32'hFFFF_FFFF, 8'h00, 32'h0, 32'h7FFF_FFFF, 1);
        send(OP_ADD, 3, 5, 1, 2, 0, 0);
        send(OP_ADD, 4, 0, 1, 2, 1, 0);
        send(OP_ADD, 1, 1, 8'h5A, 32'h1234, -1, 1);
        send(OP_ADD, 2, 1, 8'h5A, 32'h1234, 2, 1);
        for (int i = 0; i < 18; i++) send(OP_TICK, 0, 0, 0, 0, 0, 0);
        send(OP_KILL, 2, 0, 0, 0, 0, 0);
        send(OP_TAKE, 0, 0, 0, 0, 0, 0);
        send(OP_PAUSE, 0, 0, 0, 0, 0, 0);
        send(OP_TICK, 0, 0, 0, 0, 0, 0);
        send(OP_RESTART, 0, 0, 0, 0, 0, 0);
        send(OP_CHANGE, 0, 2, 0, 0, 0, 0);
        send(OP_RESUME, 0, 0, 0, 0, 0, 0);
        send(OP_KILL_ALL, 0, 0, 0, 0, 0, 0);
        send(OP_TAKE, 0, 0, 0, 0, 0, 0);
        send(4'd9, 0, 0, 0, 0, 0, 0);
        send(4'd15, 0, 0, 0, 0, 0, 0);
        // Long output stall while ticks keep coming, so the block backs up.
        for (int i = 0; i < 16; i++) send(OP_ADD, 4'(i), 1, 8'(i), i, -1, 0);
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            for (int i = 0; i < 4; i++) send(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
        join
        send(OP_KILL_ALL, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 412; i++) send_random();
        cmd_if.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
